[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle, ignored while reset is high.
`define PFSC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfsc assertion failed");

// Implication whose consequence is checked in the next cycle.
`define PFSC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfsc assertion failed");

// Consequence that must hold in the cycle after reset is seen.
`define PFSC_ASSERT_RST(name, clk, rst, cons) \
  name: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("pfsc reset assertion failed");

`endif

[rtl/pfsc_pkg.sv]
package pfsc_pkg;

  // Width of the timer period counter; the quotient is halved until it fits.
  localparam int PERIOD_WIDTH = 16;

  localparam int CLK_W    = 26;
  localparam int FREQ_W   = 32;
  localparam int DUTY_W   = 8;
  localparam int STATUS_W = 2;
  localparam int SHIFT_W  = 4;
  localparam int FIELD_W  = 16;

  // A frequency that passes the clock/20 check is below 2**(CLK_W-4).
  localparam int QUOT_W    = CLK_W;
  localparam int FREQ_LO_W = CLK_W - 4;
  localparam int TOP_W     = (PERIOD_WIDTH < QUOT_W) ? PERIOD_WIDTH : QUOT_W;
  localparam int PROD_W    = TOP_W + DUTY_W;
  localparam int QCNT_W    = $clog2(QUOT_W + 1);
  localparam int HCNT_W    = $clog2(QUOT_W + 1);
  localparam int DCNT_W    = $clog2(PROD_W + 1);

  localparam int FREQ_DIVISOR = 20;
  localparam int PERCENT      = 100;
  localparam int PCT_W        = $clog2(PERCENT);

  localparam logic [CLK_W-1:0]   CLOCK_RESET = CLK_W'(20000000);
  localparam logic [FIELD_W-1:0] FIELD_MAX   = '1;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = '1;
  localparam logic [QUOT_W-1:0]  TOP_LIMIT   = QUOT_W'((64'd1 << TOP_W) - 64'd1);

  // Smallest period top that an accepted request can produce, and the
  // smallest one after at least one halving.
  localparam logic [FIELD_W-1:0] MIN_TOP = FIELD_W'(FREQ_DIVISOR);
  localparam int SAT_W = (PERIOD_WIDTH < FIELD_W) ? PERIOD_WIDTH : FIELD_W;
  localparam logic [FIELD_W-1:0] NORM_TOP_MIN = FIELD_W'(64'd1 << (SAT_W - 1));

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FAST = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [QUOT_W-1:0] top;
    logic [HCNT_W-1:0] shift;
  } pfsc_norm_t;

endpackage

[rtl/pfsc_ifs.sv]
interface pfsc_req_if import pfsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] freq_hz;
  logic [DUTY_W-1:0] duty_percent;

  modport source(output valid, freq_hz, duty_percent, input ready);
  modport sink(input valid, freq_hz, duty_percent, output ready);
endinterface

interface pfsc_res_if import pfsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SHIFT_W-1:0]  prescale_shift;
  logic [FIELD_W-1:0]  period_top;
  logic [FIELD_W-1:0]  compare_value;

  modport source(output valid, status, prescale_shift, period_top, compare_value,
                 input ready);
  modport sink(input valid, status, prescale_shift, period_top, compare_value,
               output ready);
endinterface

interface pfsc_cfg_if import pfsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CLK_W-1:0] clock_hz;

  modport source(output valid, clock_hz, input ready);
  modport sink(input valid, clock_hz, output ready);
endinterface

[rtl/pwm_frequency_setting_calc.sv]
// PWM timer setting calculator. Each request item carries a frequency and a
// duty percentage; each result item gives a status, the prescale shift, the
// period top and the compare value for a single-slope timer clocked at
// clock_hz, the one configuration register (reset 20000000). A zero frequency
// answers with status 2 and a frequency above clock_hz/20 with status 1, both
// with all other fields zero; such a request goes straight to S_OUT. An
// accepted frequency passes the bit-serial divider, the normalizer, which
// halves the quotient until it fits, and the duty unit (a load, a serial
// multiply and a serial divide by one hundred) before it reaches S_OUT.
// From S_OUT the result is loaded into the output register once that
// register is free. One request is worked on at a time; the finished item
// waits in an output register, so the next request can be taken while it
// has not yet been collected.
module pwm_frequency_setting_calc import pfsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pfsc_req_if.sink    req,
  pfsc_res_if.source  res,
  pfsc_cfg_if.sink    cfg
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_NORM, S_DUTY, S_OUT} state_t;

  state_t              state;
  logic [CLK_W-1:0]    clock_hz;
  logic [DUTY_W-1:0]   duty_q;
  logic [STATUS_W-1:0] pend_status;
  logic [SHIFT_W-1:0]  pend_shift;
  logic [FIELD_W-1:0]  pend_top;
  logic [FIELD_W-1:0]  pend_cmp;

  logic                accept;
  logic                freq_zero;
  logic                freq_hi;
  logic [CLK_W:0]      freq_x20;
  logic                freq_fast;
  logic                out_free;

  logic                div_start;
  logic                div_done;
  logic [QUOT_W-1:0]   quot;
  logic                norm_done;
  pfsc_norm_t          norm_res;
  logic                duty_done;
  logic [PROD_W-1:0]   cmp;

  // The limit check compares 20*freq against the clock, which is the same
  // as comparing freq against the truncated clock/20. Any frequency with a
  // bit set above the low FREQ_LO_W bits is already too fast.
  always_comb begin
    accept    = req.valid && req.ready;
    freq_zero = (req.freq_hz == '0);
    freq_hi   = |req.freq_hz[FREQ_W-1:FREQ_LO_W];
    freq_x20  = (CLK_W + 1)'(req.freq_hz[FREQ_LO_W-1:0]) * (CLK_W + 1)'(FREQ_DIVISOR);
    freq_fast = freq_hi || (freq_x20 > {1'b0, clock_hz});
    div_start = accept && !freq_zero && !freq_fast;
    out_free  = !res.valid || res.ready;
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  pfsc_qdiv u_qdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (clock_hz),
    .divisor  (req.freq_hz[FREQ_LO_W-1:0]),
    .done     (div_done),
    .quot     (quot)
  );

  pfsc_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (div_done),
    .quot  (quot),
    .done  (norm_done),
    .res   (norm_res)
  );

  pfsc_duty u_duty (
    .clk   (clk),
    .rst   (rst),
    .start (norm_done),
    .top   (norm_res.top[TOP_W-1:0]),
    .duty  (duty_q),
    .done  (duty_done),
    .cmp   (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clock_hz  <= CLOCK_RESET;
      res.valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        clock_hz <= cfg.clock_hz;
      end

      // The output register drops its item once taken, unless a new one
      // is loaded in the same cycle below.
      if (res.ready) begin
        res.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            duty_q     <= req.duty_percent;
            pend_shift <= '0;
            pend_top   <= '0;
            pend_cmp   <= '0;
            if (freq_zero) begin
              pend_status <= ST_ZERO;
              state       <= S_OUT;
            end else if (freq_fast) begin
              pend_status <= ST_FAST;
              state       <= S_OUT;
            end else begin
              pend_status <= ST_OK;
              state       <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (norm_done) begin
            pend_shift <= (norm_res.shift > HCNT_W'(SHIFT_MAX)) ? SHIFT_MAX
                                                                : norm_res.shift[SHIFT_W-1:0];
            pend_top   <= (norm_res.top > QUOT_W'(FIELD_MAX)) ? FIELD_MAX
                                                              : norm_res.top[FIELD_W-1:0];
            state      <= S_DUTY;
          end
        end
        S_DUTY: begin
          if (duty_done) begin
            pend_cmp <= (cmp > PROD_W'(FIELD_MAX)) ? FIELD_MAX : cmp[FIELD_W-1:0];
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            res.valid          <= 1'b1;
            res.status         <= pend_status;
            res.prescale_shift <= pend_shift;
            res.period_top     <= pend_top;
            res.compare_value  <= pend_cmp;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/pfsc_qdiv.sv]
// Restoring divider, one quotient bit per cycle.
module pfsc_qdiv import pfsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [QUOT_W-1:0]    dividend,
  input  logic [FREQ_LO_W-1:0] divisor,
  output logic                 done,
  output logic [QUOT_W-1:0]    quot
);

  logic                 busy;
  logic [QCNT_W-1:0]    cnt;
  logic [FREQ_LO_W-1:0] rem;
  logic [FREQ_LO_W-1:0] div;
  logic [QUOT_W-1:0]    dq;
  logic [FREQ_LO_W:0]   trial;
  logic [FREQ_LO_W:0]   diff;
  logic                 qbit;

  always_comb begin
    trial = {rem, dq[QUOT_W-1]};
    diff  = trial - {1'b0, div};
    qbit  = (trial >= {1'b0, div});
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        div  <= divisor;
        dq   <= dividend;
      end else if (busy) begin
        rem <= qbit ? diff[FREQ_LO_W-1:0] : trial[FREQ_LO_W-1:0];
        dq  <= {dq[QUOT_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == QCNT_W'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = dq;

endmodule

[rtl/pfsc_norm.sv]
// Halves the quotient one bit per cycle until it fits the period counter.
module pfsc_norm import pfsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QUOT_W-1:0] quot,
  output logic              done,
  output pfsc_norm_t        res
);

  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        res.top   <= quot;
        res.shift <= '0;
      end else if (busy) begin
        if (res.top > TOP_LIMIT) begin
          res.top   <= res.top >> 1;
          res.shift <= res.shift + 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/pfsc_duty.sv]
// Compare value: a bit-serial multiply of top by duty, then a restoring
// division by one hundred, one quotient bit per cycle.
module pfsc_duty import pfsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TOP_W-1:0]  top,
  input  logic [DUTY_W-1:0] duty,
  output logic              done,
  output logic [PROD_W-1:0] cmp
);

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_DIV} dstate_t;

  dstate_t           state;
  logic [DCNT_W-1:0] cnt;
  logic [TOP_W-1:0]  mcand;
  logic [DUTY_W-1:0] dsr;
  logic [PROD_W-1:0] acc;
  logic [PCT_W-1:0]  rem;
  logic [PCT_W:0]    trial;
  logic [PCT_W:0]    diff;
  logic              qbit;
  logic [PROD_W-1:0] addend;

  always_comb begin
    addend = dsr[DUTY_W-1] ? PROD_W'(mcand) : '0;
    trial  = {rem, acc[PROD_W-1]};
    diff   = trial - (PCT_W + 1)'(PERCENT);
    qbit   = (trial >= (PCT_W + 1)'(PERCENT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            mcand <= top;
            dsr   <= duty;
            acc   <= '0;
            cnt   <= '0;
            state <= D_MUL;
          end
        end
        D_MUL: begin
          acc <= (acc << 1) + addend;
          dsr <= dsr << 1;
          cnt <= cnt + 1'b1;
          if (cnt == DCNT_W'(DUTY_W - 1)) begin
            cnt   <= '0;
            rem   <= '0;
            state <= D_DIV;
          end
        end
        D_DIV: begin
          rem <= qbit ? diff[PCT_W-1:0] : trial[PCT_W-1:0];
          acc <= {acc[PROD_W-2:0], qbit};
          cnt <= cnt + 1'b1;
          if (cnt == DCNT_W'(PROD_W - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign cmp = acc;

endmodule

[rtl/pfsc_checker.sv]
`include "assert_macros.svh"

module pfsc_checker import pfsc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input logic [STATUS_W-1:0] status,
  input logic [SHIFT_W-1:0]  prescale_shift,
  input logic [FIELD_W-1:0]  period_top,
  input logic [FIELD_W-1:0]  compare_value
);

  `PFSC_ASSERT_RST(a_rst_idle, clk, rst, !res_valid)

  `PFSC_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(status) && $stable(prescale_shift) && $stable(period_top) && $stable(compare_value))

  // A rejected request carries no timer settings.
  `PFSC_ASSERT_IMP(a_reject_zero, clk, rst, res_valid && status != ST_OK, prescale_shift == '0 && period_top == '0 && compare_value == '0)

  // An accepted frequency is at most clock/20, so the top is at least twenty.
  `PFSC_ASSERT_IMP(a_top_floor, clk, rst, res_valid && status == ST_OK, period_top >= MIN_TOP)

  // Halving stops as soon as the top fits, so a halved top keeps its high bit.
  `PFSC_ASSERT_IMP(a_norm_top, clk, rst, res_valid && status == ST_OK && prescale_shift != '0, period_top >= NORM_TOP_MIN)

endmodule

bind pwm_frequency_setting_calc pfsc_checker u_pfsc_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .status         (res.status),
  .prescale_shift (res.prescale_shift),
  .period_top     (res.period_top),
  .compare_value  (res.compare_value)
);

[verif/pwm_frequency_setting_calc_tb.sv]
module pwm_frequency_setting_calc_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfsc_pkg::*;

  // A result always comes back long before QUIET_LIMIT runs out, even with every
  // halving, so a stretch that long without any handshake can only mean a hang.
  localparam int QUIET_LIMIT = 3000;
  // Cycles to watch for stray results once nothing is expected any more.
  localparam int SETTLE_CYCLES = 100;

  // One timer setting as the block reports it.
  typedef struct packed {
    status_t            status;
    logic [SHIFT_W-1:0] shift;
    logic [FIELD_W-1:0] top;
    logic [FIELD_W-1:0] cmp_value;
  } timer_setting_t;

  logic clk;
  logic rst;

  pfsc_req_if req_if ();
  pfsc_res_if res_if ();
  pfsc_cfg_if cfg_if ();

  pwm_frequency_setting_calc dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  // Our own copy of the clock register, updated when a write is accepted.
  logic [CLK_W-1:0] clock_model = CLOCK_RESET;

  // Settings predicted for accepted requests, oldest first.
  timer_setting_t pending_settings[$];

  int error_count = 0;
  int quiet_cycles = 0;

  // Idling switches; the random and back-to-back tests set them while the block is idle.
  bit src_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Predicts the timer setting for one request under the current clock.
  // The limit and the division are done in 64 bits, so no intermediate value
  // can wrap, and the halving loop works for any period width.
  function automatic timer_setting_t predict_timer_setting(
      input logic [FREQ_W-1:0] freq, input logic [DUTY_W-1:0] duty);
    timer_setting_t   s;
    longint unsigned  top_max;
    longint unsigned  top;
    longint unsigned  halvings;
    longint unsigned  product;
    s        = '0;
    top_max  = (64'd1 << PERIOD_WIDTH) - 64'd1;
    halvings = 0;
    if (freq == '0) begin
      s.status = ST_ZERO;
    end else if (64'(freq) > 64'(clock_model) / 64'(FREQ_DIVISOR)) begin
      s.status = ST_FAST;
    end else begin
      top = 64'(clock_model) / 64'(freq);
      while (top > top_max) begin
        top >>= 1;
        halvings++;
      end
      // The compare value comes from the unsaturated top.
      product     = top * 64'(duty) / 64'(PERCENT);
      s.status    = ST_OK;
      s.shift     = (halvings > 64'(SHIFT_MAX)) ? SHIFT_MAX : SHIFT_W'(halvings);
      s.top       = (top > 64'(FIELD_MAX)) ? FIELD_MAX : FIELD_W'(top);
      s.cmp_value = (product > 64'(FIELD_MAX)) ? FIELD_MAX : FIELD_W'(product);
    end
    return s;
  endfunction

  // Picks a frequency for a random request. Most requests are ones the
  // block accepts, spread over the bit lengths below the clock/20 limit so
  // that the halving count varies; the rest sit on either side of the limit,
  // are zero, or come from the whole 32-bit range.
  function automatic logic [FREQ_W-1:0] random_freq(input logic [CLK_W-1:0] clk_val);
    longint unsigned   limit;
    logic [FREQ_W-1:0] f;
    int unsigned       pick;
    limit = 64'(clk_val) / 64'(FREQ_DIVISOR);
    pick  = $urandom_range(0, 99);
    if (pick < 5) begin
      f = '0;
    end else if (pick < 20) begin
      f = $urandom;
    end else if (pick < 30) begin
      // Wraps to a huge value when the limit is tiny, which is still legal.
      f = FREQ_W'(limit + 64'($urandom_range(0, 6)) - 64'd3);
    end else begin
      f = $urandom & ((32'd1 << $urandom_range(1, 22)) - 32'd1);
      if (limit > 0)
        f = FREQ_W'(64'd1 + 64'(f) % limit);
    end
    return f;
  endfunction

  // Compares one field and reports a mismatch with time and both values.
  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Result checker: every accepted result item is held against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    timer_setting_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_settings.size() == 0) begin
        error_count++;
        $display("%0t: result with no request waiting, expected none, actual %0d/%0d/%0d/%0d",
                 $time, res_if.status, res_if.prescale_shift, res_if.period_top,
                 res_if.compare_value);
      end else begin
        want = pending_settings.pop_front();
        check_field("status", 32'(want.status), 32'(res_if.status));
        check_field("prescale_shift", 32'(want.shift), 32'(res_if.prescale_shift));
        check_field("period_top", 32'(want.top), 32'(res_if.period_top));
        check_field("compare_value", 32'(want.cmp_value), 32'(res_if.compare_value));
      end
    end
  end

  // Result-side backpressure: when enabled, ready drops at random for a
  // burst and always comes back up before the next burst can start.
  initial begin
    int unsigned hold;
    hold = 0;
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        if (hold == 0)
          res_if.ready <= 1'b1;
      end else if (sink_stalls_on && !rst && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 14);
        res_if.ready <= 1'b0;
      end
    end
  end

  // Watchdog: counts cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: timeout, no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Sends one request item, with a random gap in front of it when source
  // gaps are enabled. Valid is left high after the item is taken, so the next
  // call can follow on the very next cycle; wait_all_results lowers it.
  task automatic send_request(input logic [FREQ_W-1:0] freq,
                              input logic [DUTY_W-1:0] duty);
    int unsigned gap;
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.freq_hz      <= freq;
    req_if.duty_percent <= duty;
    do @(posedge clk); while (!req_if.ready);
    pending_settings.push_back(predict_timer_setting(freq, duty));
  endtask

  // Random request: duty mostly within 0..100, sometimes over the top.
  task automatic send_random_request();
    logic [DUTY_W-1:0] duty;
    if ($urandom_range(0, 3) == 0)
      duty = DUTY_W'($urandom_range(0, 255));
    else
      duty = DUTY_W'($urandom_range(0, PERCENT));
    send_request(random_freq(clock_model), duty);
  endtask

  // Stops sending and waits until every predicted result has come back.
  // Every request yields exactly one result, so the block is idle then.
  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_settings.size() != 0);
  endtask

  // Writes the clock register once the block has gone idle.
  task automatic write_clock(input logic [CLK_W-1:0] value);
    wait_all_results();
    cfg_if.valid    <= 1'b1;
    cfg_if.clock_hz <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    clock_model = value;
  endtask

  // Directed items under the reset clock of 20 MHz, where the limit is 1 MHz.
  task automatic test_reset_clock();
    send_request('0, 8'd50);              // zero frequency
    send_request(32'd1, 8'd0);            // most halvings, zero duty
    send_request(32'd1, 8'd255);          // compare saturates
    send_request(32'd305, 8'd100);        // quotient just over 16 bits
    send_request(32'd306, 8'd101);        // quotient just fits, duty over 100
    send_request(32'd1000000, 8'd100);    // exactly at the limit
    send_request(32'd1000001, 8'd7);      // one above the limit
    send_request(32'hFFFFFFFF, 8'd255);   // all bits set
    send_request(32'h80000000, 8'h80);
    send_request(32'd12345, 8'd1);
  endtask

  // The clock register at its extremes, including clocks below twenty where
  // every nonzero frequency is rejected, and all-ones for the deepest shift.
  task automatic test_clock_extremes();
    write_clock('0);
    send_request('0, 8'd0);
    send_request(32'd1, 8'd50);
    write_clock(CLK_W'(19));
    send_request(32'd1, 8'd10);
    write_clock(CLK_W'(20));
    send_request(32'd1, 8'd255);          // smallest accepted top
    send_request(32'd2, 8'd50);
    write_clock('1);
    send_request(32'd1, 8'd100);
    send_request(32'd3355443, 8'd100);    // at the limit for all-ones
    send_request(32'd3355444, 8'd1);
    write_clock(CLK_W'(1000000));
    send_request(32'd1, 8'd50);
    send_request(32'd50000, 8'd99);
    write_clock(CLK_W'(50000000));
    send_request(32'd1, 8'd255);
    send_request(32'd2500000, 8'd100);
    send_request(32'd2500001, 8'd0);
  endtask

  // Random phases, each under a new clock setting, that cycle through every mix
  // of source gaps and sink stalls, including stretches with neither.
  task automatic test_random_settings();
    logic [CLK_W-1:0] clk_val;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 5))
        0:       clk_val = CLK_W'($urandom_range(0, 40));
        1:       clk_val = CLK_W'($urandom);
        default: clk_val = CLK_W'($urandom_range(1000000, 50000000));
      endcase
      write_clock(clk_val);
      src_gaps_on    = (phase % 4) < 2;
      sink_stalls_on = (phase % 2) == 0;
      repeat (125) send_random_request();
    end
  endtask

  // Last part of the run: no idling on either side, so requests and results
  // move as fast as the block allows.
  task automatic test_back_to_back();
    write_clock(CLK_W'($urandom_range(1000000, 50000000)));
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (120) send_random_request();
  endtask

  initial begin
    rst                 <= 1'b1;
    req_if.valid        <= 1'b0;
    req_if.freq_hz      <= '0;
    req_if.duty_percent <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.clock_hz     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_clock();
    test_clock_extremes();
    test_random_settings();
    test_back_to_back();

    // Everything predicted must have arrived; then watch a while longer so
    // that a stray extra result is caught by the checker.
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_settings.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/pfsc_pkg.sv
rtl/pfsc_ifs.sv
rtl/pfsc_qdiv.sv
rtl/pfsc_norm.sv
rtl/pfsc_duty.sv
rtl/pwm_frequency_setting_calc.sv
rtl/pfsc_checker.sv
verif/pwm_frequency_setting_calc_tb.sv
